// ===== rtl/slbm_pkg.sv =====
// Shared types and constants of the serial loaded bank mapper.
package slbm_pkg;

    // ROM page geometry
    localparam int ROM_PAGE_BYTES = 16384;
    localparam int MAX_ROM_PAGES  = 16;
    localparam int PAGE_OFS_W     = $clog2(ROM_PAGE_BYTES);
    localparam int PAGE_W         = $clog2(MAX_ROM_PAGES);
    localparam int ROM_OFS_W      = PAGE_W + PAGE_OFS_W;

    // Read source codes
    localparam logic [1:0] TARGET_NONE = 2'd0;
    localparam logic [1:0] TARGET_ROM  = 2'd1;
    localparam logic [1:0] TARGET_RAM  = 2'd2;

    // Register select codes, address bits 14:13 of the fifth write
    localparam logic [1:0] REG_CONTROL  = 2'd0;
    localparam logic [1:0] REG_CHR_LOW  = 2'd1;
    localparam logic [1:0] REG_CHR_HIGH = 2'd2;
    localparam logic [1:0] REG_PRG      = 2'd3;

    // Program modes, control bits 3:2 (codes 0 and 1 map one 32 KiB bank)
    localparam logic [1:0] PRG_MODE_FIX_LOW  = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_HIGH = 2'd3;

    // Bus map
    localparam logic [15:0] ADDR_RAM_BASE  = 16'h6000;
    localparam logic [15:0] ADDR_ROM_BASE  = 16'h8000;
    localparam logic [15:0] ADDR_ROM_UPPER = 16'hC000;

    localparam logic [4:0] CTRL_RESET_VAL  = 5'h0C;
    localparam logic [4:0] CTRL_MODE_BITS  = 5'h0C;
    localparam logic [2:0] SERIAL_LAST     = 3'd4;
    localparam logic [3:0] PAGE_MASK_RESET = 4'd1;

    typedef struct packed {
        logic [1:0] mirror_mode;
        logic       chr_mode;
        logic [4:0] chr_bank_low;
        logic [4:0] chr_bank_high;
        logic       ram_enabled;
    } t_status;

    typedef struct packed {
        logic [1:0]           target;
        logic [ROM_OFS_W-1:0] rom_offset;
        logic                 ram_we;
        logic                 ram_re;
        t_status              status;
    } t_access;

endpackage

// ===== rtl/slbm_if.sv =====
// Request and response channel interfaces of the serial loaded bank mapper.
interface slbm_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, func, address, write_data, input ready);
    modport sink   (input valid, func, address, write_data, output ready);
endinterface

interface slbm_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  target;
    logic [17:0] rom_offset;
    logic [7:0]  ram_data;
    logic [1:0]  mirror_mode;
    logic        chr_mode;
    logic [4:0]  chr_bank_low;
    logic [4:0]  chr_bank_high;
    logic        ram_enabled;

    modport source (output valid, target, rom_offset, ram_data, mirror_mode, chr_mode,
                    chr_bank_low, chr_bank_high, ram_enabled, input ready);
    modport sink   (input valid, target, rom_offset, ram_data, mirror_mode, chr_mode,
                    chr_bank_low, chr_bank_high, ram_enabled, output ready);
endinterface

// ===== rtl/slbm_ram.sv =====
// Generic simple dual-port RAM with registered read.
module slbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/slbm_regs.sv =====
// Serial loader, mapper registers and ROM page decode.
module slbm_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [3:0]           i_cfg_wr_data,
    input  logic                 i_accept,
    input  logic                 i_func,
    input  logic [15:0]          i_address,
    input  logic [7:0]           i_write_data,
    output slbm_pkg::t_access    o_access
);

    logic [3:0] r_page_mask;
    logic [4:0] r_serial, n_serial;
    logic [2:0] r_count, n_count;
    logic [4:0] r_control, n_control;
    logic [4:0] r_chr_low, n_chr_low;
    logic [4:0] r_chr_high, n_chr_high;
    logic [4:0] r_prg, n_prg;

    logic                        rom_space;
    logic                        ram_space;
    logic                        upper;
    logic [4:0]                  shifted;
    logic [slbm_pkg::PAGE_W-1:0] page;
    logic [slbm_pkg::PAGE_W-1:0] page_masked;

    assign rom_space = i_address >= slbm_pkg::ADDR_ROM_BASE;
    assign ram_space = (i_address >= slbm_pkg::ADDR_RAM_BASE) && !rom_space;
    assign upper     = i_address >= slbm_pkg::ADDR_ROM_UPPER;
    assign shifted   = {i_write_data[0], r_serial[4:1]};

    // Serial load and commit
    always_comb begin
        n_serial   = r_serial;
        n_count    = r_count;
        n_control  = r_control;
        n_chr_low  = r_chr_low;
        n_chr_high = r_chr_high;
        n_prg      = r_prg;
        if (i_accept && i_func && rom_space) begin
            if (i_write_data[7]) begin
                n_serial  = '0;
                n_count   = '0;
                n_control = r_control | slbm_pkg::CTRL_MODE_BITS;
            end else if (r_count == slbm_pkg::SERIAL_LAST) begin
                n_serial = '0;
                n_count  = '0;
                case (i_address[14:13])
                    slbm_pkg::REG_CONTROL:  n_control  = shifted;
                    slbm_pkg::REG_CHR_LOW:  n_chr_low  = shifted;
                    slbm_pkg::REG_CHR_HIGH: n_chr_high = shifted;
                    default:                n_prg      = shifted;
                endcase
            end else begin
                n_serial = shifted;
                n_count  = r_count + 3'd1;
            end
        end
    end

    // ROM page from the program mode; the page field already spans MAX_ROM_PAGES
    always_comb begin
        case (r_control[3:2])
            slbm_pkg::PRG_MODE_FIX_LOW:  page = upper ? r_prg[3:0] : '0;
            slbm_pkg::PRG_MODE_FIX_HIGH: page = upper ? r_page_mask : r_prg[3:0];
            default:                     page = {r_prg[3:1], upper};
        endcase
        page_masked = page & r_page_mask;
    end

    always_comb begin
        o_access.target     = slbm_pkg::TARGET_NONE;
        o_access.rom_offset = '0;
        if (!i_func && rom_space) begin
            o_access.target     = slbm_pkg::TARGET_ROM;
            o_access.rom_offset = {page_masked, i_address[slbm_pkg::PAGE_OFS_W-1:0]};
        end else if (!i_func && ram_space) begin
            o_access.target = slbm_pkg::TARGET_RAM;
        end
        o_access.ram_we               = i_accept && i_func && ram_space && !r_prg[4];
        o_access.ram_re               = i_accept && !i_func && ram_space;
        o_access.status.mirror_mode   = n_control[1:0];
        o_access.status.chr_mode      = n_control[4];
        o_access.status.chr_bank_low  = n_chr_low;
        o_access.status.chr_bank_high = n_chr_high;
        o_access.status.ram_enabled   = !n_prg[4];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_mask <= slbm_pkg::PAGE_MASK_RESET;
            r_serial    <= '0;
            r_count     <= '0;
            r_control   <= slbm_pkg::CTRL_RESET_VAL;
            r_chr_low   <= '0;
            r_chr_high  <= '0;
            r_prg       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_page_mask <= i_cfg_wr_data;
            end
            r_serial   <= n_serial;
            r_count    <= n_count;
            r_control  <= n_control;
            r_chr_low  <= n_chr_low;
            r_chr_high <= n_chr_high;
            r_prg      <= n_prg;
        end
    end

endmodule

// ===== rtl/serial_loaded_bank_mapper_core.sv =====
// Top level of the serial loaded bank mapper: request decode, program RAM, response stages.
//
//  channel   dir  beat content
//  i_req     in   func, address, write_data (one CPU bus access)
//  o_rsp     out  target, rom_offset, ram_data and mapper status after the access
//  i_cfg_*   in   rom_page_mask write, 4 bits, no read-back
//
//  One access per cycle while o_rsp is ready; beats go through RAM stage and output stage.
//  The program RAM read port sets the latency: its data lands in the cycle after accept.
//  Reset clears the serial loader and mapper registers; program RAM is not cleared.
//  A stalled o_rsp holds the output beat; one more beat waits in the RAM stage,
//  and i_req.ready drops only when both stages are full and o_rsp is stalled.
module serial_loaded_bank_mapper_core #(
    parameter int RAM_BYTES = 8192
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [3:0]        i_cfg_wr_data,
    slbm_req_if.sink          i_req,
    slbm_rsp_if.source        o_rsp
);

    localparam int RAM_AW = $clog2(RAM_BYTES);

    slbm_pkg::t_access access;

    logic              in_accept;
    logic              s1_adv;
    logic [14:0]       ram_ofs;
    logic [14:0]       ram_ofs_wrap;
    logic [RAM_AW-1:0] ram_idx;
    logic [7:0]        ram_rd_data;

    // RAM stage
    logic                               r_s1_valid;
    logic [1:0]                         r_s1_target;
    logic [slbm_pkg::ROM_OFS_W-1:0]     r_s1_rom_offset;
    slbm_pkg::t_status                  r_s1_status;

    // Output stage
    logic                               r_out_valid;
    logic [1:0]                         r_out_target;
    logic [slbm_pkg::ROM_OFS_W-1:0]     r_out_rom_offset;
    logic [7:0]                         r_out_ram_data;
    slbm_pkg::t_status                  r_out_status;

    assign s1_adv      = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_s1_valid || s1_adv;
    assign in_accept   = i_req.valid && i_req.ready;

    slbm_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (in_accept),
        .i_func        (i_req.func),
        .i_address     (i_req.address),
        .i_write_data  (i_req.write_data),
        .o_access      (access)
    );

    // Fold the 8 KiB window onto a smaller RAM: at most three wraps, checked in parallel
    always_comb begin
        ram_ofs      = {2'b00, i_req.address[12:0]};
        ram_ofs_wrap = ram_ofs;
        for (int k = 1; k < 4; k++) begin
            if (ram_ofs >= 15'(k * RAM_BYTES)) begin
                ram_ofs_wrap = ram_ofs - 15'(k * RAM_BYTES);
            end
        end
        ram_idx = ram_ofs_wrap[RAM_AW-1:0];
    end

    // Reads and writes come from distinct beats, so a read always sees earlier writes
    slbm_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_prg_ram (
        .i_clk     (i_clk),
        .i_wr_en   (access.ram_we),
        .i_wr_addr (ram_idx),
        .i_wr_data (i_req.write_data),
        .i_rd_en   (access.ram_re),
        .i_rd_addr (ram_idx),
        .o_rd_data (ram_rd_data)
    );

    // Control: advance the beat through RAM stage and output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: RAM read data is held by the RAM until the next read, which needs an accept
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_target     <= access.target;
            r_s1_rom_offset <= access.rom_offset;
            r_s1_status     <= access.status;
        end
        if (s1_adv) begin
            r_out_target     <= r_s1_target;
            r_out_rom_offset <= r_s1_rom_offset;
            r_out_ram_data   <= (r_s1_target == slbm_pkg::TARGET_RAM) ? ram_rd_data : 8'd0;
            r_out_status     <= r_s1_status;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.target        = r_out_target;
    assign o_rsp.rom_offset    = r_out_rom_offset;
    assign o_rsp.ram_data      = r_out_ram_data;
    assign o_rsp.mirror_mode   = r_out_status.mirror_mode;
    assign o_rsp.chr_mode      = r_out_status.chr_mode;
    assign o_rsp.chr_bank_low  = r_out_status.chr_bank_low;
    assign o_rsp.chr_bank_high = r_out_status.chr_bank_high;
    assign o_rsp.ram_enabled   = r_out_status.ram_enabled;

    a_ram_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(access.ram_we && access.ram_re))
        else $error("program RAM read and write in the same cycle");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_rsp.ready) |-> !in_accept)
        else $error("beat accepted while both stages are stalled");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted beat lost before the RAM stage");

    a_rom_offset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.target != slbm_pkg::TARGET_ROM) |-> o_rsp.rom_offset == '0)
        else $error("ROM offset on a beat that is not a ROM read");

    a_ram_data_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.target != slbm_pkg::TARGET_RAM) |-> o_rsp.ram_data == 8'd0)
        else $error("RAM data on a beat that is not a RAM read");

endmodule
